[design/rrsc_pkg.sv]
// Package with widths, register indexes and stage types for the rounded rectangle coverage block.
`timescale 1ns / 1ps

package rrsc_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int COV_BITS   = FRAC_BITS + 1;
   localparam int DIM_BITS   = 15;
   localparam int RADIN_BITS = 16;
   localparam int RAD_BITS   = DIM_BITS - 1;
   localparam int SD_BITS    = ((COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS) + 2;
   localparam int SQ_BITS    = 2 * DIM_BITS;
   localparam int SUM_BITS   = SQ_BITS + 1;
   localparam int SQ_SHIFT   = 2 * FRAC_BITS - 2;
   localparam int RAD_NBITS  = SUM_BITS + SQ_SHIFT;
   localparam int ROOT_BITS  = (RAD_NBITS + 1) / 2;
   localparam int REM_BITS   = ROOT_BITS + 3;
   localparam int FIN_BITS   = ROOT_BITS + 2;

   localparam int REQ_DATA_BITS = 2 * COORD_BITS;
   localparam int RSP_DATA_BITS = ((2 * COORD_BITS + COV_BITS + 7) / 8) * 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_LEFT     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_TOP      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_WIDTH    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_HEIGHT   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CORNER_RADIUS = 3'd4;

   localparam logic [COV_BITS-1:0] COV_ONE  = COV_BITS'(1) << FRAC_BITS;
   localparam logic [COV_BITS-1:0] COV_HALF = COV_BITS'(1) << (FRAC_BITS - 1);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } xy_type;

   typedef struct packed {
      xy_type                xy;
      logic [RAD_BITS-1:0]   r;
      logic                  fixed;
      logic [COV_BITS-1:0]   fcov;
   } side_type;

   typedef struct packed {
      side_type               side;
      logic [2*ROOT_BITS-1:0] n;
      logic [REM_BITS-1:0]    rem;
      logic [ROOT_BITS-1:0]   root;
   } root_type;

endpackage

[design/rounded_rect_sdf_coverage.sv]
// Top level of the pipelined rounded rectangle coverage evaluator.
//
//  port group | direction | handshake           | payload
//  req_       | in        | req_tvalid/tready   | tdata = pixel_x, pixel_y
//  rsp_       | out       | rsp_tvalid/tready   | tdata = out_x, out_y, coverage; tuser = drawn
//  csr_       | in        | csr_valid/ready     | csr_index, csr_data
//
// One pixel is accepted per clock unless the skid entry is full and the last stage holds a result.
// The depth of the pipeline is set by the square root, which resolves one root bit per stage.
// A two-entry output buffer lets the pipeline keep taking requests while a result waits.
// Reset is synchronous, clears all valid bits and returns the configuration registers to zero.
`timescale 1ns / 1ps

module rounded_rect_sdf_coverage import rrsc_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,   // pixel_x, pixel_y
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,   // out_x, out_y, coverage, zero fill
   output logic [0:0]                rsp_tuser,   // drawn
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic signed [COORD_BITS-1:0] rect_left_ff;
   logic signed [COORD_BITS-1:0] rect_top_ff;
   logic [DIM_BITS-1:0]          rect_width_ff;
   logic [DIM_BITS-1:0]          rect_height_ff;
   logic signed [RADIN_BITS-1:0] corner_radius_ff;

   logic [RAD_BITS-1:0] r_in, r_ff;
   logic [DIM_BITS-1:0] cw_in, cw_ff, ch_in, ch_ff, lim_in, lim_ff;
   logic                empty_in, empty_ff;

   logic en;

   logic                      s1_vld_ff;
   xy_type                    s1_xy_in, s1_xy_ff;
   logic signed [SD_BITS-1:0] s1_dx_in, s1_dx_ff, s1_dy_in, s1_dy_ff;

   logic                      s2_vld_ff;
   xy_type                    s2_xy_ff;
   logic signed [SD_BITS-1:0] s2_adx, s2_ady;
   logic signed [SD_BITS-1:0] s2_qx_in, s2_qx_ff, s2_qy_in, s2_qy_ff;

   logic                      s3_vld_ff;
   side_type                  s3_side_in, s3_side_ff;
   logic [DIM_BITS-1:0]       s3_ax_in, s3_ax_ff, s3_ay_in, s3_ay_ff;
   logic signed [SD_BITS-1:0] s3_inner, s3_axf, s3_ayf, s3_lim;
   logic                      s3_interior, s3_far;

   logic                s4_vld_ff;
   side_type            s4_side_ff;
   logic [SQ_BITS-1:0]  s4_ax2_ff, s4_ay2_ff;
   logic [SUM_BITS-1:0] s4_sum;

   logic     sq_vld_ff [0:ROOT_BITS];
   root_type sq_ff     [0:ROOT_BITS];
   root_type sq_in     [0:ROOT_BITS];

   logic                       fin_vld_ff;
   xy_type                     fin_xy_ff;
   logic [COV_BITS-1:0]        fin_cov_in, fin_cov_ff;
   logic signed [FIN_BITS-1:0] fin_sum;

   logic                rsp_vld_ff, sk_vld_ff;
   xy_type              rsp_xy_ff, sk_xy_ff;
   logic [COV_BITS-1:0] rsp_cov_ff, sk_cov_ff;
   logic                push, pop;

   function automatic root_type root_step(input root_type a);
      root_type            b;
      logic [REM_BITS-1:0] raw;
      logic [REM_BITS-1:0] trial;
      b     = a;
      raw   = {a.rem[REM_BITS-3:0], a.n[2*ROOT_BITS-1 -: 2]};
      trial = {1'b0, a.root, 2'b01};
      b.n   = a.n << 2;
      if (raw >= trial) begin
         b.rem  = raw - trial;
         b.root = {a.root[ROOT_BITS-2:0], 1'b1};
      end else begin
         b.rem  = raw;
         b.root = {a.root[ROOT_BITS-2:0], 1'b0};
      end
      return b;
   endfunction

   // Configuration registers.
   assign csr_ready = ~reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff     <= '0;
         rect_top_ff      <= '0;
         rect_width_ff    <= '0;
         rect_height_ff   <= '0;
         corner_radius_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RECT_LEFT:     rect_left_ff     <= $signed(csr_data[COORD_BITS-1:0]);
            CSR_RECT_TOP:      rect_top_ff      <= $signed(csr_data[COORD_BITS-1:0]);
            CSR_RECT_WIDTH:    rect_width_ff    <= csr_data[DIM_BITS-1:0];
            CSR_RECT_HEIGHT:   rect_height_ff   <= csr_data[DIM_BITS-1:0];
            CSR_CORNER_RADIUS: corner_radius_ff <= $signed(csr_data[RADIN_BITS-1:0]);
            default: ;
         endcase
      end
   end

   // Values derived from the registers; first used one stage after entry.
   always_comb begin
      logic [DIM_BITS-1:0] rr;
      logic [DIM_BITS-1:0] m;
      rr = corner_radius_ff[RADIN_BITS-1] ? '0 : corner_radius_ff[DIM_BITS-1:0];
      m  = (rect_width_ff < rect_height_ff) ? rect_width_ff : rect_height_ff;
      if ({rr, 1'b0} > {1'b0, m}) begin
         r_in = m[DIM_BITS-1:1];
      end else begin
         r_in = rr[RAD_BITS-1:0];
      end
      cw_in    = rect_width_ff - {r_in, 1'b0};
      ch_in    = rect_height_ff - {r_in, 1'b0};
      lim_in   = {r_in, 1'b1};
      empty_in = (rect_width_ff == '0) || (rect_height_ff == '0);
   end

   always_ff @(posedge clock) begin
      r_ff     <= r_in;
      cw_ff    <= cw_in;
      ch_ff    <= ch_in;
      lim_ff   <= lim_in;
      empty_ff <= empty_in;
   end

   // Pipeline enable: the last stage can always drain while the buffer has room.
   assign en         = ~fin_vld_ff | ~sk_vld_ff;
   assign req_tready = en & ~reset;

   // Stage 1: doubled offsets from the rectangle center.
   assign s1_xy_in.x = $signed(req_tdata[COORD_BITS-1:0]);
   assign s1_xy_in.y = $signed(req_tdata[2*COORD_BITS-1:COORD_BITS]);
   assign s1_dx_in   = (SD_BITS'(s1_xy_in.x) <<< 1) + SD_BITS'(1)
                       - (SD_BITS'(rect_left_ff) <<< 1) - SD_BITS'(rect_width_ff);
   assign s1_dy_in   = (SD_BITS'(s1_xy_in.y) <<< 1) + SD_BITS'(1)
                       - (SD_BITS'(rect_top_ff) <<< 1) - SD_BITS'(rect_height_ff);

   // Stage 2: distance past the straight core of the box.
   assign s2_adx   = s1_dx_ff[SD_BITS-1] ? -s1_dx_ff : s1_dx_ff;
   assign s2_ady   = s1_dy_ff[SD_BITS-1] ? -s1_dy_ff : s1_dy_ff;
   assign s2_qx_in = s2_adx - $signed(SD_BITS'(cw_ff));
   assign s2_qy_in = s2_ady - $signed(SD_BITS'(ch_ff));

   // Stage 3: inside, far outside, or in a corner that needs the root.
   always_comb begin
      s3_interior = (s2_qx_ff <= 0) && (s2_qy_ff <= 0);
      s3_inner    = (s2_qx_ff > s2_qy_ff) ? s2_qx_ff : s2_qy_ff;
      s3_axf      = (s2_qx_ff > 0) ? s2_qx_ff : '0;
      s3_ayf      = (s2_qy_ff > 0) ? s2_qy_ff : '0;
      s3_lim      = $signed(SD_BITS'(lim_ff));
      s3_far      = (s3_axf > s3_lim) || (s3_ayf > s3_lim);
      s3_side_in.xy    = s2_xy_ff;
      s3_side_in.r     = r_ff;
      s3_side_in.fixed = empty_ff | s3_interior | s3_far;
      if (empty_ff || !s3_interior) begin
         s3_side_in.fcov = '0;
      end else if ((s3_inner == 0) && (r_ff == '0)) begin
         s3_side_in.fcov = COV_HALF;
      end else begin
         s3_side_in.fcov = COV_ONE;
      end
      s3_ax_in = s3_axf[DIM_BITS-1:0];
      s3_ay_in = s3_ayf[DIM_BITS-1:0];
   end

   // Stage 5 input: sum of squares scaled for the root.
   assign s4_sum          = SUM_BITS'(s4_ax2_ff) + SUM_BITS'(s4_ay2_ff);
   assign sq_in[0].side   = s4_side_ff;
   assign sq_in[0].n      = (2*ROOT_BITS)'(s4_sum) << SQ_SHIFT;
   assign sq_in[0].rem    = '0;
   assign sq_in[0].root   = '0;

   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
      assign sq_in[k+1] = root_step(sq_ff[k]);
   end

   // Final stage: coverage from the root.
   always_comb begin
      fin_sum = $signed(FIN_BITS'(COV_HALF))
                + $signed(FIN_BITS'(sq_ff[ROOT_BITS].side.r) << FRAC_BITS)
                - $signed(FIN_BITS'(sq_ff[ROOT_BITS].root));
      if (sq_ff[ROOT_BITS].side.fixed) begin
         fin_cov_in = sq_ff[ROOT_BITS].side.fcov;
      end else if (fin_sum[FIN_BITS-1]) begin
         fin_cov_in = '0;
      end else if (fin_sum > $signed(FIN_BITS'(COV_ONE))) begin
         fin_cov_in = COV_ONE;
      end else begin
         fin_cov_in = fin_sum[COV_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         fin_vld_ff <= 1'b0;
         for (int k = 0; k <= ROOT_BITS; k++) begin
            sq_vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         s1_vld_ff    <= req_tvalid;
         s2_vld_ff    <= s1_vld_ff;
         s3_vld_ff    <= s2_vld_ff;
         s4_vld_ff    <= s3_vld_ff;
         sq_vld_ff[0] <= s4_vld_ff;
         for (int k = 0; k < ROOT_BITS; k++) begin
            sq_vld_ff[k+1] <= sq_vld_ff[k];
         end
         fin_vld_ff <= sq_vld_ff[ROOT_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_xy_ff   <= s1_xy_in;
         s1_dx_ff   <= s1_dx_in;
         s1_dy_ff   <= s1_dy_in;
         s2_xy_ff   <= s1_xy_ff;
         s2_qx_ff   <= s2_qx_in;
         s2_qy_ff   <= s2_qy_in;
         s3_side_ff <= s3_side_in;
         s3_ax_ff   <= s3_ax_in;
         s3_ay_ff   <= s3_ay_in;
         s4_side_ff <= s3_side_ff;
         s4_ax2_ff  <= SQ_BITS'(s3_ax_ff) * SQ_BITS'(s3_ax_ff);
         s4_ay2_ff  <= SQ_BITS'(s3_ay_ff) * SQ_BITS'(s3_ay_ff);
         for (int k = 0; k <= ROOT_BITS; k++) begin
            sq_ff[k] <= sq_in[k];
         end
         fin_xy_ff  <= sq_ff[ROOT_BITS].side.xy;
         fin_cov_ff <= fin_cov_in;
      end
   end

   // Output register with one skid entry behind it.
   assign push = fin_vld_ff & ~sk_vld_ff;
   assign pop  = rsp_vld_ff & rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
         sk_vld_ff  <= 1'b0;
      end else if (sk_vld_ff) begin
         if (pop) begin
            sk_vld_ff <= 1'b0;
         end
      end else if (push) begin
         if (!rsp_vld_ff || pop) begin
            rsp_vld_ff <= 1'b1;
         end else begin
            sk_vld_ff <= 1'b1;
         end
      end else if (pop) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (sk_vld_ff) begin
         if (pop) begin
            rsp_xy_ff  <= sk_xy_ff;
            rsp_cov_ff <= sk_cov_ff;
         end
      end else if (push) begin
         if (!rsp_vld_ff || pop) begin
            rsp_xy_ff  <= fin_xy_ff;
            rsp_cov_ff <= fin_cov_ff;
         end else begin
            sk_xy_ff  <= fin_xy_ff;
            sk_cov_ff <= fin_cov_ff;
         end
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = RSP_DATA_BITS'({rsp_cov_ff, rsp_xy_ff.y, rsp_xy_ff.x});
   assign rsp_tuser[0] = (rsp_cov_ff != '0);

endmodule

[design/rrsc_checker.sv]
// Port-level checker for the rounded rectangle coverage block, with its bind.
`timescale 1ns / 1ps

module rrsc_checker import rrsc_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata,
   input logic [0:0]               rsp_tuser
);

   logic [COV_BITS-1:0] cov;

   assign cov = rsp_tdata[2*COORD_BITS+COV_BITS-1:2*COORD_BITS];

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("A stalled response was withdrawn.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("A stalled response changed.");

   a_drawn: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser[0] == (cov != '0)))
      else $error("The drawn flag disagrees with the coverage.");

   a_cov_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (cov <= COV_ONE))
      else $error("Coverage is above full.");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("A response is valid right after reset.");

endmodule

bind rounded_rect_sdf_coverage rrsc_checker u_rrsc_checker (.*);
